### rtl/core/pen_point_smoother_decimator_unit_macros.svh
// assertion macros for the pen point smoother
`ifndef PEN_POINT_SMOOTHER_DECIMATOR_UNIT_MACROS_SVH
`define PEN_POINT_SMOOTHER_DECIMATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/ppsd_pkg.sv
package ppsd_pkg;

    localparam int COORD_W        = 20;
    localparam int DEF_MAX_WINDOW = 8;
    localparam int BLEND_W        = 9;
    localparam int WLEN_W         = 4;
    localparam int STEP_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int FRAC_SHIFT     = 8;

    localparam logic [BLEND_W-1:0] BLEND_ONE = 9'd256;
    localparam logic [BLEND_W-1:0] BLEND_RST = 9'd166;
    localparam logic [WLEN_W-1:0]  WLEN_RST  = 4'd4;
    localparam logic [STEP_W-1:0]  STEP_RST  = 16'd16;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_END   = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND = 2'd0,
        CFG_WLEN  = 2'd1,
        CFG_STEP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
    } t_in_item;

    typedef struct packed {
        logic                       accepted;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_MEAN,
        ST_MUL,
        ST_BLEND,
        ST_DIST,
        ST_SQR,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic do_start;
        logic do_end;
        logic do_drop;
        logic raw_pass;
        logic walk_init;
        logic walk_step;
        logic div_init;
        logic div_step;
        logic mean_load;
        logic mul_load;
        logic blend_load;
        logic dist_load;
        logic sqr_load;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       active;
        logic       hist_empty;
        logic       walk_done;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

### rtl/core/ppsd_div.sv
module ppsd_div
    import ppsd_pkg::*;
#(
    parameter int  MAX_WINDOW = DEF_MAX_WINDOW,
    localparam int SUMW       = COORD_W + $clog2(MAX_WINDOW),
    localparam int CW         = $clog2(MAX_WINDOW + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_init,
    input  logic                      i_step,
    input  logic signed [SUMW-1:0]    i_dividend,
    input  logic [CW-1:0]             i_divisor,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_mean
);

    localparam int BW = $clog2(SUMW + 1);

    logic [SUMW-1:0] r_q;
    logic [CW-1:0]   r_rem;
    logic            r_neg;
    logic [BW-1:0]   r_bits;

    logic [SUMW-1:0] w_mag;
    logic [CW:0]     w_trial;
    logic [CW:0]     w_diff;
    logic            w_ge;
    logic [SUMW-1:0] w_mean_full;

    assign w_mag   = i_dividend[SUMW-1] ? SUMW'(-i_dividend) : i_dividend;
    assign w_trial = {r_rem, r_q[SUMW-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    // floor rounding for a negative sum
    assign w_mean_full = r_neg ? (~r_q + SUMW'(r_rem == '0)) : r_q;
    assign o_mean      = w_mean_full[COORD_W-1:0];
    assign o_done      = (r_bits == BW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_init) begin
            r_bits <= BW'(SUMW);
        end else if (i_step && (r_bits != '0)) begin
            r_bits <= r_bits - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_neg <= i_dividend[SUMW-1];
        end else if (i_step) begin
            r_q   <= {r_q[SUMW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
        end
    end

endmodule

### rtl/core/ppsd_ctrl.sv
module ppsd_ctrl
    import ppsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.func)
                    FUNC_MOVE: begin
                        if (!i_sts.active) begin
                            n_state = ST_DONE;
                        end else if (i_sts.hist_empty) begin
                            n_state = ST_DIST;
                        end else begin
                            n_state = ST_SUM;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SUM: begin
                if (i_sts.walk_done) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_BLEND;
            ST_BLEND: n_state = ST_DIST;
            ST_DIST:  n_state = ST_SQR;
            ST_SQR:   n_state = ST_CMP;
            ST_CMP:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                case (i_sts.func)
                    FUNC_START: o_cmd.do_start = 1'b1;
                    FUNC_END:   o_cmd.do_end   = 1'b1;
                    FUNC_MOVE: begin
                        if (!i_sts.active) begin
                            o_cmd.do_drop = 1'b1;
                        end else if (i_sts.hist_empty) begin
                            o_cmd.raw_pass = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                        end
                    end
                    default: o_cmd.do_drop = 1'b1;
                endcase
            end
            ST_SUM:      o_cmd.walk_step  = 1'b1;
            ST_DIV_INIT: o_cmd.div_init   = 1'b1;
            ST_DIV:      o_cmd.div_step   = 1'b1;
            ST_MEAN:     o_cmd.mean_load  = 1'b1;
            ST_MUL:      o_cmd.mul_load   = 1'b1;
            ST_BLEND:    o_cmd.blend_load = 1'b1;
            ST_DIST:     o_cmd.dist_load  = 1'b1;
            ST_SQR:      o_cmd.sqr_load   = 1'b1;
            ST_CMP:      o_cmd.commit     = 1'b1;
            ST_DONE:     o_cmd.out_load   = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/ppsd_dpath.sv
`include "pen_point_smoother_decimator_unit_macros.svh"

module ppsd_dpath
    import ppsd_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = COORD_W + $clog2(MAX_WINDOW);
    localparam int PW   = COORD_W + BLEND_W + 1;
    localparam int DW   = COORD_W + 1;
    localparam int QW   = 2 * STEP_W;

    // configuration
    logic [BLEND_W-1:0] r_blend;
    logic [WLEN_W-1:0]  r_wlen;
    logic [STEP_W-1:0]  r_step;

    // item and stroke state
    logic [1:0]                r_func;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic signed [COORD_W-1:0] r_last_x, r_last_y;
    logic [AW-1:0]             r_head;
    logic [CW-1:0]             r_count;
    logic                      r_active;

    // history
    logic signed [COORD_W-1:0] mem_x [MAX_WINDOW];
    logic signed [COORD_W-1:0] mem_y [MAX_WINDOW];
    logic signed [COORD_W-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0]             r_ptr;
    logic [CW-1:0]             r_walk_cnt;
    logic [CW-1:0]             r_acc_cnt;
    logic                      r_rd_vld;
    logic signed [SUMW-1:0]    r_acc_x, r_acc_y;

    // blend and distance
    logic signed [COORD_W-1:0] r_mx, r_my;
    logic signed [PW-1:0]      r_pa_x, r_pb_x, r_pa_y, r_pb_y;
    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic [DW-1:0]             r_adx, r_ady;
    logic                      r_big;
    logic [QW-1:0]             r_sq_x, r_sq_y, r_sq_m;

    // result and output
    t_out_item                 r_res;
    t_out_item                 r_out_data;
    logic                      r_out_valid;

    logic                      w_push;
    logic [AW-1:0]             w_push_addr;
    logic signed [COORD_W-1:0] w_push_x, w_push_y;
    logic [AW-1:0]             w_head_prev;
    logic [AW-1:0]             w_ptr_prev;
    logic [AW-1:0]             w_push_next;
    logic [CW-1:0]             w_win;
    logic [CW:0]               w_cnt_inc;
    logic [CW-1:0]             w_cnt_new;
    logic [BLEND_W-1:0]        w_f;
    logic [BLEND_W-1:0]        w_g;
    logic signed [PW:0]        w_sum_x, w_sum_y;
    logic signed [DW-1:0]      w_dx, w_dy;
    logic [DW-1:0]             w_adx, w_ady;
    logic [QW:0]               w_sq_sum;
    logic                      w_ok;
    logic signed [COORD_W-1:0] w_mean_x, w_mean_y;
    logic                      w_done_x, w_done_y;

    ppsd_div #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_acc_x),
        .i_divisor  (r_count),
        .o_done     (w_done_x),
        .o_mean     (w_mean_x)
    );

    ppsd_div #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_acc_y),
        .i_divisor  (r_count),
        .o_done     (w_done_y),
        .o_mean     (w_mean_y)
    );

    // ring pointer arithmetic
    assign w_head_prev = (r_head == '0) ? AW'(MAX_WINDOW - 1) : r_head - 1'b1;
    assign w_ptr_prev  = (r_ptr == '0) ? AW'(MAX_WINDOW - 1) : r_ptr - 1'b1;

    assign w_push      = i_cmd.do_start || (i_cmd.commit && w_ok);
    assign w_push_addr = i_cmd.do_start ? '0 : r_head;
    assign w_push_x    = i_cmd.do_start ? r_px : r_sx;
    assign w_push_y    = i_cmd.do_start ? r_py : r_sy;
    assign w_push_next = (w_push_addr == AW'(MAX_WINDOW - 1)) ? '0 : w_push_addr + 1'b1;

    assign w_win     = (int'(r_wlen) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(r_wlen);
    assign w_cnt_inc = {1'b0, r_count} + 1'b1;
    assign w_cnt_new = (w_cnt_inc > {1'b0, w_win}) ? w_win : w_cnt_inc[CW-1:0];

    assign w_f = (r_blend > BLEND_ONE) ? BLEND_ONE : r_blend;
    assign w_g = BLEND_ONE - w_f;

    assign w_sum_x = (PW+1)'(r_pa_x) + (PW+1)'(r_pb_x);
    assign w_sum_y = (PW+1)'(r_pa_y) + (PW+1)'(r_pb_y);

    assign w_dx  = DW'(r_sx) - DW'(r_last_x);
    assign w_dy  = DW'(r_sy) - DW'(r_last_y);
    assign w_adx = w_dx[DW-1] ? DW'(-w_dx) : w_dx;
    assign w_ady = w_dy[DW-1] ? DW'(-w_dy) : w_dy;

    assign w_sq_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_ok     = r_big || (w_sq_sum >= {1'b0, r_sq_m});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= BLEND_RST;
            r_wlen  <= WLEN_RST;
            r_step  <= STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BLEND: r_blend <= i_cfg_data[BLEND_W-1:0];
                CFG_WLEN:  r_wlen  <= i_cfg_data[WLEN_W-1:0];
                CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_head   <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (i_cmd.do_start) begin
            r_active <= 1'b1;
            r_count  <= CW'(1);
            r_head   <= w_push_next;
            r_last_x <= r_px;
            r_last_y <= r_py;
        end else if (i_cmd.do_end) begin
            r_active <= 1'b0;
            r_count  <= '0;
        end else if (i_cmd.commit && w_ok) begin
            r_count  <= w_cnt_new;
            r_head   <= w_push_next;
            r_last_x <= r_sx;
            r_last_y <= r_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem_x[w_push_addr] <= w_push_x;
            mem_y[w_push_addr] <= w_push_y;
        end
        r_rd_x <= mem_x[r_ptr];
        r_rd_y <= mem_y[r_ptr];
    end

    // history walk, newest entry first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_walk_cnt <= '0;
            r_acc_cnt  <= '0;
            r_ptr      <= '0;
        end else if (i_cmd.walk_init) begin
            r_rd_vld   <= 1'b0;
            r_walk_cnt <= r_count;
            r_acc_cnt  <= r_count;
            r_ptr      <= w_head_prev;
        end else if (i_cmd.walk_step) begin
            r_rd_vld <= (r_walk_cnt != '0);
            if (r_walk_cnt != '0) begin
                r_walk_cnt <= r_walk_cnt - 1'b1;
                r_ptr      <= w_ptr_prev;
            end
            if (r_rd_vld) begin
                r_acc_cnt <= r_acc_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_in_data.func;
            r_px   <= i_in_data.pos_x;
            r_py   <= i_in_data.pos_y;
        end
        if (i_cmd.walk_init) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (i_cmd.walk_step && r_rd_vld) begin
            r_acc_x <= r_acc_x + SUMW'(r_rd_x);
            r_acc_y <= r_acc_y + SUMW'(r_rd_y);
        end
        if (i_cmd.mean_load) begin
            r_mx <= w_mean_x;
            r_my <= w_mean_y;
        end
        if (i_cmd.mul_load) begin
            r_pa_x <= $signed({1'b0, w_g}) * r_px;
            r_pb_x <= $signed({1'b0, w_f}) * r_mx;
            r_pa_y <= $signed({1'b0, w_g}) * r_py;
            r_pb_y <= $signed({1'b0, w_f}) * r_my;
        end
        if (i_cmd.raw_pass) begin
            r_sx <= r_px;
            r_sy <= r_py;
        end else if (i_cmd.blend_load) begin
            r_sx <= w_sum_x[FRAC_SHIFT +: COORD_W];
            r_sy <= w_sum_y[FRAC_SHIFT +: COORD_W];
        end
        if (i_cmd.dist_load) begin
            r_adx <= w_adx;
            r_ady <= w_ady;
        end
        // the squares are used only when both offsets are below min step, so 16-bit squares suffice
        if (i_cmd.sqr_load) begin
            r_big  <= (r_adx >= DW'(r_step)) || (r_ady >= DW'(r_step));
            r_sq_x <= r_adx[STEP_W-1:0] * r_adx[STEP_W-1:0];
            r_sq_y <= r_ady[STEP_W-1:0] * r_ady[STEP_W-1:0];
            r_sq_m <= r_step * r_step;
        end
        if (i_cmd.do_start) begin
            r_res.accepted <= 1'b1;
            r_res.out_x    <= r_px;
            r_res.out_y    <= r_py;
        end else if (i_cmd.do_end || i_cmd.do_drop) begin
            r_res <= '0;
        end else if (i_cmd.commit) begin
            r_res.accepted <= w_ok;
            r_res.out_x    <= r_sx;
            r_res.out_y    <= r_sy;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.func       = r_func;
    assign o_sts.active     = r_active;
    assign o_sts.hist_empty = (r_count == '0);
    assign o_sts.walk_done  = r_rd_vld && (r_acc_cnt == CW'(1));
    assign o_sts.div_done   = w_done_x && w_done_y;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)
    `ASSERT_IMPLIES(a_walk_has_hist, i_clk, i_rst_n, i_cmd.walk_init, r_count != '0)
    `ASSERT_NEXT(a_start_opens, i_clk, i_rst_n, i_cmd.do_start, r_active && (r_count == CW'(1)))

endmodule

### rtl/core/pen_point_smoother_decimator_unit.sv
// Pen point smoother and decimator. Each input beat is a pen sample tagged stroke start,
// move or stroke end; each one yields exactly one output beat. A start echoes the point
// as accepted and restarts the history; a move is blended with the floor mean of the
// history window, (256 - blend_weight) * raw + blend_weight * mean over 256, and is
// accepted and pushed when its distance from the last accepted point reaches min_step;
// an end closes the stroke. A move with an empty history is not blended; other tags
// and moves outside a stroke give a zero beat that is not accepted. One item is in
// flight at a time. The history walk reads one history entry per cycle and the
// bit-serial mean divider produces one quotient bit per cycle. Output beats are held
// in an output register, so a new input beat can be taken while a result waits.
// Configuration writes take effect at once and are meant for idle periods only.
module pen_point_smoother_decimator_unit
    import ppsd_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    ppsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppsd_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### dv/pen_point_smoother_decimator_unit_test.sv
`timescale 1ns / 100ps

module pen_point_smoother_decimator_unit_test
    import ppsd_pkg::*;
();

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int GAP_MAX = 18;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int EXP_DEPTH = 16;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    localparam int BLEND_SET [NUM_PHASES] = '{0, 256, 511, 128, 166, 40, 300, 200};
    localparam int WLEN_SET [NUM_PHASES] = '{1, 8, 15, 0, 3, 8, 12, 2};
    localparam int MIN_STEP_SET [NUM_PHASES] = '{0, 65535, 16, 8, 40, 1, 200, 4096};

    class smoothed_point_board;
        longint trail_x [DEF_MAX_WINDOW];
        longint trail_y [DEF_MAX_WINDOW];
        int unsigned trail_count;
        int unsigned trail_head;
        longint anchor_x;
        longint anchor_y;
        bit in_stroke;
        int unsigned blend = BLEND_RST;
        int unsigned wlen = WLEN_RST;
        longint min_step = STEP_RST;
        t_out_item smoothed_q [EXP_DEPTH];
        int unsigned q_wr;
        int unsigned q_rd;
        int unsigned q_cnt;
        int unsigned bad_points;

        static function longint floor_quot(longint num, longint den);
            longint q;
            q = num / den;
            if (num % den != 0 && num < 0) q = q - 1;
            return q;
        endfunction

        function void push_trail(longint px, longint py);
            trail_x[trail_head] = px;
            trail_y[trail_head] = py;
            trail_head = (trail_head + 1) % DEF_MAX_WINDOW;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BLEND: blend = value[BLEND_W-1:0];
                CFG_WLEN: wlen = value[WLEN_W-1:0];
                CFG_STEP: min_step = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_bad(string msg);
            if (bad_points < 10) $display("%s", msg);
            bad_points++;
        endfunction

        function void expect_point(t_out_item res);
            if (q_cnt == EXP_DEPTH) begin
                note_bad("expected beat store overflow");
                return;
            end
            smoothed_q[q_wr] = res;
            q_wr = (q_wr + 1) % EXP_DEPTH;
            q_cnt++;
        endfunction

        function void take_sample(t_in_item it);
            t_out_item res;
            longint px, py, sx, sy, sum_x, sum_y, wf, adx, ady;
            int unsigned k, slot, lim;
            bit ok;
            res = '0;
            px = $signed(it.pos_x);
            py = $signed(it.pos_y);
            case (it.func)
                FUNC_START: begin
                    trail_count = 0;
                    trail_head = 0;
                    push_trail(px, py);
                    trail_count = 1;
                    anchor_x = px;
                    anchor_y = py;
                    in_stroke = 1'b1;
                    res.accepted = 1'b1;
                    res.out_x = it.pos_x;
                    res.out_y = it.pos_y;
                end
                FUNC_MOVE: begin
                    if (in_stroke) begin
                        sx = px;
                        sy = py;
                        if (trail_count > 0) begin
                            sum_x = 0;
                            sum_y = 0;
                            for (k = 1; k <= trail_count; k++) begin
                                slot = (trail_head + 2 * DEF_MAX_WINDOW - k) % DEF_MAX_WINDOW;
                                sum_x += trail_x[slot];
                                sum_y += trail_y[slot];
                            end
                            wf = (blend > 256) ? 256 : blend;
                            sx = floor_quot((256 - wf) * px
                                + wf * floor_quot(sum_x, trail_count), 256);
                            sy = floor_quot((256 - wf) * py
                                + wf * floor_quot(sum_y, trail_count), 256);
                        end
                        adx = sx - anchor_x;
                        ady = sy - anchor_y;
                        if (adx < 0) adx = -adx;
                        if (ady < 0) ady = -ady;
                        ok = adx >= min_step || ady >= min_step
                            || adx * adx + ady * ady >= min_step * min_step;
                        if (ok) begin
                            anchor_x = sx;
                            anchor_y = sy;
                            lim = (wlen > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : wlen;
                            push_trail(sx, sy);
                            trail_count++;
                            if (trail_count > lim) trail_count = lim;
                        end
                        res.accepted = ok;
                        res.out_x = sx[COORD_W-1:0];
                        res.out_y = sy[COORD_W-1:0];
                    end
                end
                FUNC_END: begin
                    in_stroke = 1'b0;
                    trail_count = 0;
                end
                default: ;
            endcase
            expect_point(res);
        endfunction

        function void check_point(t_out_item got);
            t_out_item want;
            if (q_cnt == 0) begin
                note_bad($sformatf("unexpected output beat: acc %0d x %0d y %0d",
                    got.accepted, $signed(got.out_x), $signed(got.out_y)));
                return;
            end
            want = smoothed_q[q_rd];
            q_rd = (q_rd + 1) % EXP_DEPTH;
            q_cnt--;
            if (got.accepted !== want.accepted || got.out_x !== want.out_x
                    || got.out_y !== want.out_y) begin
                note_bad($sformatf("mismatch: want acc %0d x %0d y %0d, got acc %0d x %0d y %0d",
                    want.accepted, $signed(want.out_x), $signed(want.out_y),
                    got.accepted, $signed(got.out_x), $signed(got.out_y)));
            end
        endfunction

        function int pending();
            return int'(q_cnt);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit no_idle = 1'b0;
    int idle_cycles = 0;
    smoothed_point_board board = new();

    always #5 clk = ~clk;

    pen_point_smoother_decimator_unit #(
        .MAX_WINDOW(DEF_MAX_WINDOW)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    function automatic t_in_item make_item(input logic [1:0] func, input int x, input int y);
        t_in_item it;
        it.func = func;
        it.pos_x = x[COORD_W-1:0];
        it.pos_y = y[COORD_W-1:0];
        return it;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        board.take_sample(it);
    endtask

    // hold off input until every pending result has drained
    task automatic go_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] blend_val,
                                  input logic [CFG_DATA_W-1:0] wlen_val,
                                  input logic [CFG_DATA_W-1:0] step_val);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_BLEND;
        cfg_data <= blend_val;
        @(posedge clk);
        board.set_register(CFG_BLEND, blend_val);
        cfg_idx <= CFG_WLEN;
        cfg_data <= wlen_val;
        @(posedge clk);
        board.set_register(CFG_WLEN, wlen_val);
        cfg_idx <= CFG_STEP;
        cfg_data <= step_val;
        @(posedge clk);
        board.set_register(CFG_STEP, step_val);
        cfg_we <= 1'b0;
    endtask

    task automatic run_strokes(input int quota);
        int done_items, len, scale, x, y;
        t_in_item it;
        done_items = 0;
        while (done_items < quota) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 29) == 0) go_idle();
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 1) == 1) begin
                    x = rand_coord();
                    y = rand_coord();
                end else begin
                    x = int'($urandom_range(0, 4000)) - 2000;
                    y = int'($urandom_range(0, 4000)) - 2000;
                end
                send_item(make_item(FUNC_START, x, y));
                len = $urandom_range(1, 20);
                scale = 2 << (3 * $urandom_range(0, 5));
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0) begin
                        x = rand_coord();
                        y = rand_coord();
                    end else begin
                        x = clamp_coord(x + int'($urandom_range(0, 2 * scale)) - scale);
                        y = clamp_coord(y + int'($urandom_range(0, 2 * scale)) - scale);
                    end
                    send_item(make_item(FUNC_MOVE, x, y));
                end
                done_items += len + 1;
                if ($urandom_range(0, 6) != 0) begin
                    send_item(make_item(FUNC_END, x, y));
                    done_items++;
                end
            end else begin
                it = make_item(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
                send_item(it);
                done_items++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("pen_point_smoother_decimator_unit_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        wait (rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_point(out_data);
        end
    end

    initial begin
        int phase, k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        send_item(make_item(FUNC_MOVE, 100, -100));
        send_item(make_item(FUNC_END, 0, 0));
        send_item(make_item(FUNC_START, COORD_MAX, COORD_MIN));
        send_item(make_item(FUNC_MOVE, COORD_MIN, COORD_MAX));
        send_item(make_item(FUNC_MOVE, COORD_MIN, COORD_MAX));
        send_item(make_item(FUNC_IGNORED, -1, -1));
        send_item(make_item(FUNC_START, 0, 0));
        send_item(make_item(FUNC_MOVE, 1, 1));
        send_item(make_item(FUNC_MOVE, -1, -3));
        for (k = 1; k <= 6; k++) send_item(make_item(FUNC_MOVE, k * 400, -k * 300));
        send_item(make_item(FUNC_END, 5, 5));
        send_item(make_item(FUNC_MOVE, 500, 500));
        send_item(make_item(FUNC_START, COORD_MIN, COORD_MIN));
        send_item(make_item(FUNC_MOVE, COORD_MAX, COORD_MAX));
        go_idle();
        send_item(make_item(FUNC_END, COORD_MAX, COORD_MIN));

        // saturated weight, empty history, no minimum step
        go_idle();
        write_settings(16'd511, 16'd0, 16'd0);
        send_item(make_item(FUNC_START, 10, 10));
        send_item(make_item(FUNC_MOVE, 9, 10));
        send_item(make_item(FUNC_MOVE, -20, 40));
        send_item(make_item(FUNC_END, 0, 0));

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            go_idle();
            write_settings(CFG_DATA_W'(BLEND_SET[phase]), CFG_DATA_W'(WLEN_SET[phase]),
                CFG_DATA_W'(MIN_STEP_SET[phase]));
            run_strokes(PHASE_ITEMS);
        end

        go_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.bad_points == 0 && board.pending() == 0) begin
            $display("pen_point_smoother_decimator_unit_test: PASS");
        end else begin
            $display("pen_point_smoother_decimator_unit_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ppsd_pkg.sv
rtl/core/ppsd_div.sv
rtl/core/ppsd_ctrl.sv
rtl/core/ppsd_dpath.sv
rtl/core/pen_point_smoother_decimator_unit.sv
dv/pen_point_smoother_decimator_unit_test.sv
